### sv/float36_add_mul_div_assert.svh
// Assertion macros for the float36 add/multiply/divide unit.
// Used by the port checker; needs clk and rst_n in scope.
`ifndef FLOAT36_ADD_MUL_DIV_ASSERT_SVH
`define FLOAT36_ADD_MUL_DIV_ASSERT_SVH

// same-cycle implication
`define F36_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("f36 check failed");

// next-cycle implication
`define F36_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("f36 check failed");

`endif

### sv/f36_pkg.sv
// Shared types and constants for the float36 add/multiply/divide unit.
// No dependencies.
package f36_pkg;

  localparam int EXP_W    = 12;
  localparam int IN_TDW   = 80;
  localparam int OUT_TDW  = 48;

  localparam logic [63:0] W_NORM  = 64'h4000000000000000;
  localparam logic [63:0] W_CARRY = 64'h8000000000000000;
  localparam logic [63:0] W_ROUND = 64'h0000000800000000;
  localparam logic [63:0] W_FRAC  = 64'h7FFFFFFFFFFFFFFE;
  localparam logic [63:0] W_KEEP  = 64'h7FFFFFF800000000;

  localparam logic signed [EXP_W-1:0] EXP_BIAS = 12'sd128;
  localparam logic signed [EXP_W-1:0] EXP_MAX  = 12'sd255;
  localparam logic [5:0] MAX_ALIGN = 6'd63;
  localparam logic [5:0] MUL_STEPS = 6'd27;
  localparam logic [5:0] DIV_STEPS = 6'd29;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // result tdata bit positions
  localparam int OB_WRITTEN = 36;
  localparam int OB_AOV     = 37;
  localparam int OB_FOV     = 38;
  localparam int OB_FXU     = 39;
  localparam int OB_DCK     = 40;

  typedef struct packed {
    logic                    sign;
    logic signed [EXP_W-1:0] exp;
    logic [63:0]             frac;
  } wnum_t;

endpackage

### sv/f36_unpack.sv
// Unpacks a 36-bit float word into sign, exponent and 64-bit working fraction.
// Depends on f36_pkg.
module f36_unpack import f36_pkg::*; (
  input  logic [35:0] word,
  input  logic        signed_frac,
  output wnum_t       num
);

  logic [63:0] raw;

  always_comb begin
    raw      = {1'b0, word[26:0], 36'd0};
    num.sign = word[35];
    num.exp  = $signed({4'd0, word[34:27]});
    num.frac = raw;
    if (word[35]) begin
      num.exp = $signed({4'd0, ~word[34:27]});
      if (raw == 64'd0) begin
        // negative word with empty fraction: one half, exponent up by one
        num.exp  = num.exp + 12'sd1;
        num.frac = signed_frac ? (W_CARRY | W_NORM) : W_NORM;
      end else if (signed_frac) begin
        num.frac = raw | W_CARRY;
      end else begin
        num.frac = (~raw + 64'd1) & W_FRAC;
      end
    end
  end

endmodule

### sv/float36_add_mul_div.sv
// Top level of the float36 add/subtract/multiply/divide unit.
// Depends on f36_pkg and f36_unpack.
//
// One operation at a time: in_tready is high only while the unit is idle.
// A 64-bit working fraction is worked step by step under a sequencer.
// Multiply takes 27 shift-add steps and divide 29 restoring steps;
// add/subtract aligns 8 or 1 bits per cycle. Normalize shifts left 8 or
// 1 bits per cycle. The time from the accepting edge to out_tvalid is set,
// for add/subtract, by the exponent difference and how far the sum must be
// normalized; multiply and divide take longer for poorly normalized
// operands; a zero factor, a zero dividend or a divide check goes straight
// to the done state. A result sits in an output register, so the next
// operation is accepted while it waits.
module float36_add_mul_div import f36_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  // opcode[1:0], operand_a[37:2], operand_b[73:38], round_enable[74]
  input  logic [IN_TDW-1:0]  in_tdata,
  output logic               out_tvalid,
  input  logic               out_tready,
  // result_word[35:0], result_written[36], arith_overflow[37],
  // float_overflow[38], float_underflow[39], divide_check[40]
  output logic [OUT_TDW-1:0] out_tdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_ALIGN, S_ADD, S_MUL, S_MULFIX, S_DIV, S_DIVFIX,
    S_NORM, S_ROUND, S_PACK, S_DONE
  } state_t;

  state_t                  state_r, state_nxt;
  logic                    rnd_r, rnd_nxt;
  logic                    a_sign_r, a_sign_nxt, b_sign_r, b_sign_nxt;
  logic signed [EXP_W-1:0] a_exp_r, a_exp_nxt;
  logic [63:0]             a_frac_r, a_frac_nxt, b_frac_r, b_frac_nxt;
  logic [5:0]              cnt_r, cnt_nxt;
  logic [28:0]             mq_r, mq_nxt;
  logic [27:0]             rem_r, rem_nxt;
  logic                    inexact_r, inexact_nxt;
  logic [40:0]             res_r, res_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_TDW-1:0]      out_data_r, out_data_nxt;

  logic [1:0]  in_op;
  logic [35:0] in_x, in_y, y_eff;
  logic        in_rnd, is_add, both_nz;
  wnum_t       ua, ub;
  logic signed [EXP_W-1:0] dexp, dmag;
  logic [26:0] fa, fb;
  logic [63:0] sum, s2;
  logic [28:0] dtry;
  logic [63:0] qf;
  logic [35:0] pv;

  assign in_op  = in_tdata[1:0];
  assign in_x   = in_tdata[37:2];
  assign in_y   = in_tdata[73:38];
  assign in_rnd = in_tdata[74];
  assign is_add = (in_op == OP_ADD) || (in_op == OP_SUB);
  assign y_eff  = (in_op == OP_SUB) ? (~in_y + 36'd1) : in_y;
  assign both_nz = (in_x != 36'd0) && (y_eff != 36'd0);

  f36_unpack u_unp_a (.word(in_x),  .signed_frac(is_add && both_nz), .num(ua));
  f36_unpack u_unp_b (.word(y_eff), .signed_frac(is_add && both_nz), .num(ub));

  assign fa   = ua.frac[62:36];
  assign fb   = ub.frac[62:36];
  assign dexp = ua.exp - ub.exp;
  assign dmag = dexp[EXP_W-1] ? -dexp : dexp;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    a_sign_nxt    = a_sign_r;
    b_sign_nxt    = b_sign_r;
    a_exp_nxt     = a_exp_r;
    a_frac_nxt    = a_frac_r;
    b_frac_nxt    = b_frac_r;
    cnt_nxt       = cnt_r;
    mq_nxt        = mq_r;
    rem_nxt       = rem_r;
    inexact_nxt   = inexact_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    sum  = a_frac_r + b_frac_r;
    s2   = sum;
    dtry = {1'b0, rem_r} - {2'b0, b_frac_r[26:0]};
    qf   = {1'b0, mq_r, 34'd0};
    pv   = {1'b0, a_exp_r[7:0], a_frac_r[62:36]};

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          rnd_nxt     = in_rnd;
          inexact_nxt = 1'b0;
          res_nxt     = '0;
          res_nxt[OB_WRITTEN-1+1] = 1'b1;
          a_sign_nxt  = ua.sign;
          a_exp_nxt   = ua.exp;
          a_frac_nxt  = ua.frac;
          b_sign_nxt  = ub.sign;
          b_frac_nxt  = ub.frac;
          unique case (op_t'(in_op))
            OP_ADD, OP_SUB: begin
              if (in_x == 36'd0) begin
                a_sign_nxt = ub.sign;
                a_exp_nxt  = ub.exp;
                a_frac_nxt = ub.frac;
                state_nxt  = S_NORM;
              end else if (y_eff == 36'd0) begin
                state_nxt  = S_NORM;
              end else begin
                if (dexp[EXP_W-1]) begin
                  a_sign_nxt = ub.sign;
                  a_exp_nxt  = ub.exp;
                  a_frac_nxt = ub.frac;
                  b_sign_nxt = ua.sign;
                  b_frac_nxt = ua.frac;
                end
                cnt_nxt   = (dmag > $signed({6'd0, MAX_ALIGN})) ? MAX_ALIGN : dmag[5:0];
                state_nxt = S_ALIGN;
              end
            end
            OP_MUL: begin
              if (fa == 27'd0 || fb == 27'd0) begin
                state_nxt = S_DONE;
              end else begin
                a_sign_nxt = ua.sign ^ ub.sign;
                a_exp_nxt  = ua.exp + ub.exp - EXP_BIAS + 12'sd1;
                a_frac_nxt = '0;
                b_frac_nxt = {37'd0, fb};
                mq_nxt     = {2'd0, fa};
                cnt_nxt    = MUL_STEPS;
                state_nxt  = S_MUL;
              end
            end
            OP_DIV: begin
              if ({1'b0, fa} >= {fb, 1'b0}) begin
                res_nxt[OB_WRITTEN] = 1'b0;
                res_nxt[OB_AOV]     = 1'b1;
                res_nxt[OB_FOV]     = 1'b1;
                res_nxt[OB_DCK]     = 1'b1;
                state_nxt = S_DONE;
              end else if (fa == 27'd0) begin
                state_nxt = S_DONE;
              end else begin
                a_sign_nxt = ua.sign ^ ub.sign;
                a_exp_nxt  = ua.exp - ub.exp + EXP_BIAS + 12'sd1;
                b_frac_nxt = {37'd0, fb};
                rem_nxt    = {1'b0, fa};
                mq_nxt     = '0;
                cnt_nxt    = DIV_STEPS;
                state_nxt  = S_DIV;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_ALIGN: begin
        if (cnt_r == 6'd0) begin
          state_nxt = S_ADD;
        end else if (cnt_r >= 6'd8) begin
          b_frac_nxt = $unsigned($signed(b_frac_r) >>> 8);
          cnt_nxt    = cnt_r - 6'd8;
        end else begin
          b_frac_nxt = $unsigned($signed(b_frac_r) >>> 1);
          cnt_nxt    = cnt_r - 6'd1;
        end
      end
      S_ADD: begin
        if (a_sign_r ^ b_sign_r) begin
          if (sum[63]) begin
            a_frac_nxt = ~sum + 64'd1;
            a_sign_nxt = 1'b1;
          end else begin
            a_frac_nxt = sum;
            a_sign_nxt = 1'b0;
          end
        end else begin
          s2 = a_sign_r ? (~sum + 64'd1) : sum;
          if (s2[63]) begin
            a_frac_nxt = s2 >> 1;
            a_exp_nxt  = a_exp_r + 12'sd1;
          end else begin
            a_frac_nxt = s2;
          end
        end
        state_nxt = S_NORM;
      end
      S_MUL: begin
        if (cnt_r == 6'd0) begin
          state_nxt = S_MULFIX;
        end else begin
          a_frac_nxt = (a_frac_r << 1) + (mq_r[26] ? b_frac_r : 64'd0);
          mq_nxt     = mq_r << 1;
          cnt_nxt    = cnt_r - 6'd1;
        end
      end
      S_MULFIX: begin
        a_frac_nxt = a_frac_r << 8;
        state_nxt  = S_NORM;
      end
      S_DIV: begin
        if (cnt_r == 6'd0) begin
          state_nxt = S_DIVFIX;
        end else begin
          // restoring step: one quotient bit, remainder doubled for the next
          if (!dtry[28]) begin
            mq_nxt  = {mq_r[27:0], 1'b1};
            rem_nxt = {dtry[26:0], 1'b0};
          end else begin
            mq_nxt  = {mq_r[27:0], 1'b0};
            rem_nxt = {rem_r[26:0], 1'b0};
          end
          cnt_nxt = cnt_r - 6'd1;
        end
      end
      S_DIVFIX: begin
        inexact_nxt = a_sign_r && (rem_r != 28'd0);
        if (!qf[62]) begin
          a_frac_nxt = (qf << 1) & W_KEEP;
          a_exp_nxt  = a_exp_r - 12'sd1;
        end else begin
          a_frac_nxt = qf & W_KEEP;
        end
        state_nxt = S_NORM;
      end
      S_NORM: begin
        priority if (a_frac_r[63]) begin
          a_frac_nxt = a_frac_r >> 1;
          a_exp_nxt  = a_exp_r + 12'sd1;
        end else if (a_frac_r == 64'd0) begin
          a_sign_nxt = 1'b0;
          a_exp_nxt  = '0;
          state_nxt  = S_PACK;
        end else if (!a_frac_r[62]) begin
          if (a_frac_r[62:55] == 8'd0) begin
            a_frac_nxt = a_frac_r << 8;
            a_exp_nxt  = a_exp_r - 12'sd8;
          end else begin
            a_frac_nxt = a_frac_r << 1;
            a_exp_nxt  = a_exp_r - 12'sd1;
          end
        end else begin
          state_nxt = rnd_r ? S_ROUND : S_PACK;
        end
      end
      S_ROUND: begin
        s2 = a_frac_r + W_ROUND;
        if (s2[63]) begin
          a_frac_nxt = s2 >> 1;
          a_exp_nxt  = a_exp_r + 12'sd1;
        end else begin
          a_frac_nxt = s2;
        end
        state_nxt = S_PACK;
      end
      S_PACK: begin
        if (a_exp_r < 12'sd0) begin
          res_nxt[OB_AOV] = 1'b1;
          res_nxt[OB_FOV] = 1'b1;
          res_nxt[OB_FXU] = 1'b1;
        end else if (a_exp_r > EXP_MAX) begin
          res_nxt[OB_AOV] = 1'b1;
          res_nxt[OB_FOV] = 1'b1;
        end
        if (a_sign_r) pv = inexact_r ? ~pv : (~pv + 36'd1);
        res_nxt[35:0] = pv;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{(OUT_TDW-41){1'b0}}, res_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rnd_r      <= rnd_nxt;
    a_sign_r   <= a_sign_nxt;
    b_sign_r   <= b_sign_nxt;
    a_exp_r    <= a_exp_nxt;
    a_frac_r   <= a_frac_nxt;
    b_frac_r   <= b_frac_nxt;
    cnt_r      <= cnt_nxt;
    mq_r       <= mq_nxt;
    rem_r      <= rem_nxt;
    inexact_r  <= inexact_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

### sv/f36_chk.sv
// Port-level checker for the float36 unit, bound to the top level.
// Depends on f36_pkg and float36_add_mul_div_assert.svh.
`include "float36_add_mul_div_assert.svh"

module f36_chk import f36_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_tvalid,
  input logic               out_tready,
  input logic [OUT_TDW-1:0] out_tdata
);

  `F36_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `F36_ASSERT_IMPL(a_dck_nostore, out_tvalid && out_tdata[OB_DCK], !out_tdata[OB_WRITTEN] && out_tdata[35:0] == 36'd0)
  `F36_ASSERT_IMPL(a_unwritten_dck, out_tvalid && !out_tdata[OB_WRITTEN], out_tdata[OB_DCK])
  `F36_ASSERT_IMPL(a_fxu_flags, out_tvalid && out_tdata[OB_FXU], out_tdata[OB_FOV] && out_tdata[OB_AOV])
  `F36_ASSERT_IMPL(a_fov_aov, out_tvalid && out_tdata[OB_FOV], out_tdata[OB_AOV])

endmodule

bind float36_add_mul_div f36_chk u_f36_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
